// ----- design/cff_pkg.sv -----
// Package for the circular FIR filter: sizes, register indexes and the
// command and status types between the controller and the datapath.
// No dependencies.
package cff_pkg;

	localparam int TAP_COUNT   = 8;
	localparam int COEF_COUNT  = 8;
	localparam int SAMPLE_W    = 16;
	localparam int COEF_W      = 16;
	localparam int FRAC_W      = 15;
	localparam int OUT_W       = 20;
	localparam int PROD_W      = SAMPLE_W + COEF_W;
	localparam int ACC_W       = OUT_W + FRAC_W;
	localparam int CFG_IDX_W   = 4;
	localparam int COEF_IDX_W  = $clog2(COEF_COUNT);
	localparam int RING_IDX_W  = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;
	localparam int CNT_W       = $clog2(TAP_COUNT + 1);

	localparam logic signed [COEF_W-1:0] COEF_RESET = 16'sd4096;

	localparam logic [CFG_IDX_W-1:0] REG_COEF_TAP0 = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_TAP7 = 4'd7;

	typedef struct packed {
		logic                  start;
		logic                  mul_en;
		logic                  acc_en;
		logic                  load;
		logic [COEF_IDX_W-1:0] tap;
	} cff_cmd_t;

	typedef struct packed {
		logic out_busy;
	} cff_status_t;

endpackage

// ----- design/cff_ctrl.sv -----
// Controller for the circular FIR filter: sequences the multiply-accumulate
// steps for one sample and the load of the output register.
// Depends on cff_pkg.
module cff_ctrl import cff_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  cff_status_t status,
	output cff_cmd_t    cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_LOAD = 2'd2;

	logic [1:0]       state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             last;

	assign last     = (cnt_q == CNT_W'(TAP_COUNT));
	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		cmd.start  = (state_q == ST_IDLE) && in_valid;
		cmd.mul_en = (state_q == ST_RUN) && !last;
		cmd.acc_en = (state_q == ST_RUN) && (cnt_q != '0);
		cmd.load   = (state_q == ST_LOAD) && !status.out_busy;
		cmd.tap    = COEF_IDX_W'(cnt_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_RUN;
						cnt_q   <= '0;
					end
				end
				ST_RUN: begin
					if (last) begin
						state_q <= ST_LOAD;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_LOAD: begin
					if (!status.out_busy) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- design/cff_datapath.sv -----
// Datapath for the circular FIR filter: sample ring, coefficient registers,
// one shared multiplier with a product register, accumulator and output beat.
// Depends on cff_pkg.
module cff_datapath import cff_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cff_cmd_t                   cmd,
	output cff_status_t                status,
	input  logic                       cfg_valid,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic signed [COEF_W-1:0]   cfg_data,
	input  logic signed [SAMPLE_W-1:0] sample_in,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [OUT_W-1:0]    filtered_out
);

	logic signed [SAMPLE_W-1:0] ring_q [TAP_COUNT];
	logic signed [COEF_W-1:0]   coef_q [COEF_COUNT];
	logic [RING_IDX_W-1:0]      wr_idx_q;
	logic [RING_IDX_W-1:0]      rd_idx_q;
	logic signed [PROD_W-1:0]   prod_s1;
	logic signed [ACC_W-1:0]    acc_q;
	logic                       out_valid_q;
	logic signed [OUT_W-1:0]    out_q;

	assign status.out_busy = out_valid_q && out_stall;
	assign out_valid       = out_valid_q;
	assign filtered_out    = out_q;

	function automatic logic [RING_IDX_W-1:0] wrap_inc(input logic [RING_IDX_W-1:0] idx);
		if (idx == RING_IDX_W'(TAP_COUNT - 1)) begin
			return '0;
		end
		return idx + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < COEF_COUNT; i++) begin
				coef_q[i] <= COEF_RESET;
			end
		end else if (cfg_valid && (cfg_index <= REG_COEF_TAP7)) begin
			coef_q[cfg_index[COEF_IDX_W-1:0]] <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TAP_COUNT; i++) begin
				ring_q[i] <= '0;
			end
			wr_idx_q <= '0;
			rd_idx_q <= '0;
		end else begin
			if (cmd.start) begin
				ring_q[wr_idx_q] <= sample_in;
				rd_idx_q         <= wr_idx_q;
			end else if (cmd.mul_en) begin
				rd_idx_q <= wrap_inc(rd_idx_q);
			end
			if (cmd.load) begin
				wr_idx_q <= wrap_inc(wr_idx_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_s1 <= coef_q[cmd.tap] * ring_q[rd_idx_q];
		end
		if (cmd.start) begin
			acc_q <= '0;
		end else if (cmd.acc_en) begin
			acc_q <= acc_q + ACC_W'(prod_s1);
		end
		if (cmd.load) begin
			out_q <= acc_q[ACC_W-1:FRAC_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

// ----- design/circular_fir_filter.sv -----
// Top level of the eight-tap circular-buffer FIR filter in fixed point.
// Depends on cff_pkg, cff_ctrl and cff_datapath.
//
// Channel   Direction  Handshake              Payload
// input     in         in_valid / in_stall    sample_in (16-bit signed)
// output    out        out_valid / out_stall  filtered_out (20-bit signed)
// config    in         cfg_valid / cfg_ready  cfg_index (4 bits), cfg_data (16 bits)
//
// From its accepted beat, a sample takes TAP_COUNT + 1 passes of the shared
// multiply-accumulate and then a load state, where its result loads into the
// output register. The next sample is taken no earlier than the cycle after
// the load, so no sample is taken while one is in flight. Reset clears the
// ring and the write index and sets every coefficient to 1/8. A stalled output
// beat holds; a new sample is taken while it waits, and its result loads once
// the held beat has gone.
module circular_fir_filter import cff_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic signed [SAMPLE_W-1:0] sample_in,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [OUT_W-1:0]    filtered_out,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic signed [COEF_W-1:0]   cfg_data
);

	cff_cmd_t    cmd;
	cff_status_t status;

	assign cfg_ready = 1'b1;

	cff_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	cff_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.cfg_valid    (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.sample_in    (sample_in),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.filtered_out (filtered_out)
	);

endmodule

// ----- design/cff_checker.sv -----
// Port-level checker for the circular FIR filter, bound to the top level.
// Depends on cff_pkg.
module cff_checker import cff_pkg::*; (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_stall,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic signed [OUT_W-1:0]    filtered_out
);

	logic in_beat;

	assign in_beat = in_valid && !in_stall;

	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> in_stall)
		else $error("input taken again right after a beat");

	a_busy_through_mac: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |-> ##10 in_stall)
		else $error("input taken before the result was loaded");

	a_no_out_during_mac: assert property (@(posedge clk) disable iff (!arst_n)
		(in_beat && !out_valid) |-> ##9 !out_valid)
		else $error("result appeared before the accumulation finished");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(filtered_out)))
		else $error("stalled output beat changed");

endmodule

bind circular_fir_filter cff_checker u_cff_checker (.*);

// ----- tb/sv/cff_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard for the circular FIR filter: watches the sample, result and
// coefficient channels, predicts every filtered result and compares it.
// Depends on cff_pkg.
module cff_scoreboard import cff_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_stall,
	input  logic signed [SAMPLE_W-1:0] sample_in,
	input  logic                       out_valid,
	input  logic                       out_stall,
	input  logic signed [OUT_W-1:0]    filtered_out,
	input  logic                       cfg_valid,
	input  logic                       cfg_ready,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic signed [COEF_W-1:0]   cfg_data,
	output int                         errors,
	output int                         pending
);

	logic signed [COEF_W-1:0]   tap_coefs [COEF_COUNT];
	logic signed [SAMPLE_W-1:0] history [TAP_COUNT];
	logic [RING_IDX_W-1:0]      newest_pos;
	logic signed [OUT_W-1:0]    filtered_q [$];

	always @(posedge clk or negedge arst_n) begin
		longint                  acc;
		logic [RING_IDX_W-1:0]   pos;
		logic signed [OUT_W-1:0] want;

		if (!arst_n) begin
			foreach (tap_coefs[k])
				tap_coefs[k] = COEF_RESET;
			foreach (history[k])
				history[k] = '0;
			newest_pos = '0;
			filtered_q.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready && cfg_index <= REG_COEF_TAP7)
				tap_coefs[COEF_IDX_W'(cfg_index - REG_COEF_TAP0)] = cfg_data;

			if (in_valid && !in_stall) begin
				history[newest_pos] = sample_in;
				acc = 0;
				pos = newest_pos;
				for (int k = 0; k < TAP_COUNT; k++) begin
					acc += longint'(tap_coefs[k]) * longint'(history[pos]);
					pos = (pos == TAP_COUNT - 1) ? '0 : pos + 1'b1;
				end
				filtered_q.push_back(OUT_W'(acc >>> FRAC_W));
				newest_pos = (newest_pos == TAP_COUNT - 1) ? '0 : newest_pos + 1'b1;
			end

			if (out_valid && !out_stall) begin
				if (filtered_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t: result beat %0d with no sample pending", $time,
							filtered_out);
				end else begin
					want = filtered_q.pop_front();
					if (filtered_out !== want) begin
						errors++;
						if (errors <= 10)
							$display("%0t: filtered_out expected %0d, got %0d", $time, want,
								filtered_out);
					end
				end
			end
			pending = filtered_q.size();
		end
	end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// Top of the circular FIR filter testbench: clock, reset, sample and
// coefficient stimulus with random idling, and the verdict. Depends on
// cff_pkg, circular_fir_filter and cff_scoreboard.
module tb_top import cff_pkg::*; ();

	localparam int SETTLE_CYCLES = 16;

	typedef enum {TAPS_DEFAULT, TAPS_EXTREME, TAPS_RANDOM, TAPS_IMPULSE} tap_set_t;

	logic                       clk;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_stall;
	logic signed [SAMPLE_W-1:0] sample_in;
	logic                       out_valid;
	logic                       out_stall;
	logic signed [OUT_W-1:0]    filtered_out;
	logic                       cfg_valid;
	logic                       cfg_ready;
	logic [CFG_IDX_W-1:0]       cfg_index;
	logic signed [COEF_W-1:0]   cfg_data;
	int                         errors;
	int                         pending;
	bit                         calm;

	circular_fir_filter DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.sample_in    (sample_in),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.filtered_out (filtered_out),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	cff_scoreboard checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.sample_in    (sample_in),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.filtered_out (filtered_out),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.errors       (errors),
		.pending      (pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Mismatches found");
		$finish;
	end

	// The receiver holds off each result beat for a random number of cycles.
	initial begin
		int hold;

		out_stall = 1'b1;
		forever begin
			hold = calm ? 0 : $urandom_range(0, 8);
			out_stall = 1'b1;
			repeat (hold) @(negedge clk);
			out_stall = 1'b0;
			do @(posedge clk); while (out_valid !== 1'b1);
			@(negedge clk);
		end
	end

	task automatic put_sample(input logic signed [SAMPLE_W-1:0] value);
		int gap;

		gap = calm ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		sample_in = value;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic settle_filter();
		in_valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic signed [COEF_W-1:0] value);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic program_taps(input tap_set_t kind);
		logic signed [COEF_W-1:0] value;
		int                       hot;

		hot = $urandom_range(0, TAP_COUNT - 1);
		for (int k = 0; k < COEF_COUNT; k++) begin
			case (kind)
				TAPS_DEFAULT: value = COEF_RESET;
				TAPS_EXTREME: value = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
				TAPS_RANDOM:  value = COEF_W'($urandom);
				default:      value = (k == hot) ? COEF_W'($urandom | 1) : '0;
			endcase
			write_reg(CFG_IDX_W'(REG_COEF_TAP0 + k), value);
		end
		// Indexes past the last tap must leave the coefficients untouched.
		write_reg(CFG_IDX_W'(REG_COEF_TAP7 + 1 + $urandom_range(0, 7)), COEF_W'($urandom));
	endtask

	initial begin
		logic signed [SAMPLE_W-1:0] value;

		arst_n = 1'b0;
		in_valid = 1'b0;
		sample_in = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		calm = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Moving average straight out of reset, then the output extremes.
		repeat (3) put_sample(16'sh7FFF);
		repeat (3) put_sample(16'sh8000);
		put_sample(16'sh0000);
		put_sample(16'sh0001);
		put_sample(-16'sh0001);
		settle_filter();
		for (int k = 0; k < COEF_COUNT; k++)
			write_reg(CFG_IDX_W'(REG_COEF_TAP0 + k), 16'sh8000);
		write_reg(CFG_IDX_W'(REG_COEF_TAP7 + 1), '0);
		write_reg(CFG_IDX_W'('1), '0);
		repeat (TAP_COUNT) put_sample(16'sh8000);
		settle_filter();
		for (int k = 0; k < COEF_COUNT; k++)
			write_reg(CFG_IDX_W'(REG_COEF_TAP0 + k), 16'sh7FFF);
		repeat (TAP_COUNT) put_sample(16'sh8000);
		settle_filter();

		for (int phase = 0; phase < 7; phase++) begin
			calm = (phase % 3 == 2);
			case (phase % 4)
				0: program_taps(TAPS_RANDOM);
				1: program_taps(TAPS_IMPULSE);
				2: program_taps(TAPS_EXTREME);
				default: program_taps(phase == 3 ? TAPS_DEFAULT : TAPS_RANDOM);
			endcase
			repeat (100) begin
				case ($urandom_range(0, 9))
					0: value = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
					1: value = SAMPLE_W'($urandom_range(0, 2)) - 1'b1;
					default: value = SAMPLE_W'($urandom);
				endcase
				put_sample(value);
			end
			settle_filter();
		end

		if (errors == 0 && pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ----- files.f -----
design/cff_pkg.sv
design/cff_ctrl.sv
design/cff_datapath.sv
design/circular_fir_filter.sv
design/cff_checker.sv
tb/sv/cff_checker.sv
tb/sv/tb_top.sv
